>>> design/hlew_pkg.sv
// hlew_pkg: shared constants, codes and types for the hourly load edge weight unit.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package hlew_pkg;

    // Field widths
    localparam int NODE_W  = 8;
    localparam int HOUR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int TIME_W  = 32;

    // Table geometry
    localparam int NODE_COUNT  = 1 << NODE_W;
    localparam int HOURS       = 24;
    localparam int TABLE_DEPTH = NODE_COUNT * HOURS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Time constants
    localparam int SEC_W         = 17;
    localparam int SEC_PER_DAY   = 86400;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int HALF_HOUR     = 1800;
    localparam int FRAC_W        = 12;

    // t mod 86400: 86400 = 675 << 7, so fold t >> 7 by 675.
    // q = (u * DAY_RECIP) >> 35 is exact for u < 2^25.
    localparam int          DAY_SHIFT       = 7;
    localparam int          DAY_ODD         = SEC_PER_DAY / (1 << DAY_SHIFT);
    localparam int          DAY_U_W         = TIME_W - DAY_SHIFT;
    localparam int          DAY_RECIP_W     = 26;
    localparam int          DAY_RECIP_SHIFT = 35;
    localparam int          DAY_Q_W         = 16;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;

    // x / 3600 for x < 86400: (x >> 4) * 9321 >> 21, exact.
    localparam int          HOUR_SHIFT       = 4;
    localparam int          HOUR_X_W         = SEC_W - HOUR_SHIFT;
    localparam int          HOUR_RECIP_W     = 14;
    localparam int          HOUR_RECIP_SHIFT = 21;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = 14'd9321;

    // num / 3600 for num < 2^44: (num >> 4) * LOAD_RECIP >> 47, exact.
    localparam int          NUM_W            = 44;
    localparam int          LOAD_Y_W         = NUM_W - HOUR_SHIFT;
    localparam int          LOAD_RECIP_W     = 40;
    localparam int          LOAD_RECIP_HALF  = LOAD_RECIP_W / 2;
    localparam int          LOAD_RECIP_SHIFT = 47;
    localparam int          LOAD_PP_W        = LOAD_Y_W + LOAD_RECIP_HALF;
    localparam int          LOAD_SUM_W       = LOAD_Y_W + LOAD_RECIP_W;
    localparam logic [LOAD_RECIP_W-1:0] LOAD_RECIP = 40'd625499948246;

    // Weight rounding: Q24.8 load times Q16.16 scale, drop 24 fraction bits
    localparam int          PROD_W      = 2 * DATA_W;
    localparam int          WEIGHT_FRAC = 24;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h80_0000);

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_WEIGH = 1'b1;

    // Config registers
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODE  = 1'd1;
    localparam logic [DATA_W-1:0]    SCALE_RESET = 32'd65536;
    localparam logic                 MODE_RESET  = 1'b1;

    // Result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef logic [HOURS-1:0] hour_mask_t;

    typedef struct packed {
        logic [DATA_W-1:0] weight;
        logic              unmatched;
    } rsp_entry_t;

endpackage

`default_nettype wire

>>> design/hlew_req_if.sv
// hlew_req_if: request channel (write or weigh items) with valid/ready.
// Depends on hlew_pkg for field widths.
`default_nettype none

interface hlew_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [hlew_pkg::NODE_W-1:0]   node_index;
    logic [hlew_pkg::HOUR_W-1:0]   hour_slot;
    logic [hlew_pkg::DATA_W-1:0]   load_value;
    logic [hlew_pkg::TIME_W-1:0]   departure_time;

    modport source (
        output valid, req_type, node_index, hour_slot, load_value, departure_time,
        input  ready
    );

    modport sink (
        input  valid, req_type, node_index, hour_slot, load_value, departure_time,
        output ready
    );
endinterface

`default_nettype wire

>>> design/hlew_rsp_if.sv
// hlew_rsp_if: result channel (edge weight and unmatched flag) with valid/ready.
// Depends on hlew_pkg for field widths.
`default_nettype none

interface hlew_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hlew_pkg::DATA_W-1:0]   crowd_weight;
    logic                          stop_unmatched;

    modport source (
        output valid, crowd_weight, stop_unmatched,
        input  ready
    );

    modport sink (
        input  valid, crowd_weight, stop_unmatched,
        output ready
    );
endinterface

`default_nettype wire

>>> design/hourly_load_edge_weight_unit.sv
// hourly_load_edge_weight_unit: hourly load table and edge weight pipeline.
// Depends on hlew_pkg, hlew_req_if and hlew_rsp_if.
//
//   Channel   Kind         Carries                                      Transfer when
//   req       in  v/r      req_type node_index hour_slot load_value     valid && ready
//                          departure_time
//   rsp       out v/r      crowd_weight stop_unmatched                  valid && ready
//   apb       cfg          scale_unit (0x0), interpolate_mode (0x4)     psel&penable&pwrite
//
// Throughput is one request per cycle while req.ready is high. A weigh request
// passes through 10 pipeline stages, then the result queue, on its way to rsp.
// Write requests give no result and leave the pipe after the mask update.
// req.ready drops only while 16 weigh results are in flight or queued; the
// 16-entry result queue sets that limit, so rsp stalls never stop the pipe.
// Reset clears the 256 row-valid flags at once; no clearing pass is needed.
`default_nettype none

module hourly_load_edge_weight_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    hlew_req_if.sink                           req,
    hlew_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hlew_pkg::PADDR_W-1:0]       paddr,
    input  logic [hlew_pkg::DATA_W-1:0]        pwdata,
    output logic [hlew_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [hlew_pkg::DATA_W-1:0]    scale_reg;
    logic                           mode_reg;
    logic                           cfg_wr;
    logic [hlew_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[hlew_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= hlew_pkg::SCALE_RESET;
            mode_reg  <= hlew_pkg::MODE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                hlew_pkg::REG_SCALE: scale_reg <= pwdata;
                hlew_pkg::REG_MODE:  mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            hlew_pkg::REG_SCALE: prdata = scale_reg;
            hlew_pkg::REG_MODE:  prdata = {{(hlew_pkg::DATA_W-1){1'b0}}, mode_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Credit: weigh results accepted but not yet delivered
    // ------------------------------------------------------------------
    logic [hlew_pkg::CNT_W-1:0] pending_reg;
    logic [hlew_pkg::CNT_W-1:0] pending_next;
    logic                       accept;
    logic                       weigh_accept;
    logic                       rsp_xfer;

    assign req.ready    = pending_reg < hlew_pkg::CNT_W'(hlew_pkg::FIFO_DEPTH);
    assign accept       = req.valid && req.ready;
    assign weigh_accept = accept && (req.req_type == hlew_pkg::REQ_WEIGH);
    assign rsp_xfer     = rsp.valid && rsp.ready;

    always_comb
    begin
        pending_next = pending_reg;
        case ({weigh_accept, rsp_xfer})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // ------------------------------------------------------------------
    // Stage valids. Stages 1..5 carry writes and weighs, 6..10 weighs only.
    // ------------------------------------------------------------------
    logic [10:1] vld_reg;
    logic        p5_weigh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            vld_reg[1]    <= accept;
            vld_reg[5:2]  <= vld_reg[4:1];
            vld_reg[6]    <= vld_reg[5] && (p5_weigh_reg == hlew_pkg::REQ_WEIGH);
            vld_reg[10:7] <= vld_reg[9:6];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: t >> 7 times reciprocal of 675
    // ------------------------------------------------------------------
    logic                                  p1_weigh_reg;
    logic [hlew_pkg::NODE_W-1:0]           p1_node_reg;
    logic [hlew_pkg::HOUR_W-1:0]           p1_hour_reg;
    logic [hlew_pkg::DATA_W-1:0]           p1_value_reg;
    logic [hlew_pkg::TIME_W-1:0]           p1_time_reg;
    logic [hlew_pkg::DAY_U_W-1:0]          p1_u;
    logic [hlew_pkg::DAY_U_W+hlew_pkg::DAY_RECIP_W-1:0] p1_prod;

    assign p1_u    = p1_time_reg[hlew_pkg::TIME_W-1:hlew_pkg::DAY_SHIFT];
    assign p1_prod = (hlew_pkg::DAY_U_W+hlew_pkg::DAY_RECIP_W)'(p1_u)
                   * (hlew_pkg::DAY_U_W+hlew_pkg::DAY_RECIP_W)'(hlew_pkg::DAY_RECIP);

    // ------------------------------------------------------------------
    // Stage 2: remainder mod 675 gives seconds of day
    // ------------------------------------------------------------------
    logic                                  p2_weigh_reg;
    logic [hlew_pkg::NODE_W-1:0]           p2_node_reg;
    logic [hlew_pkg::HOUR_W-1:0]           p2_hour_reg;
    logic [hlew_pkg::DATA_W-1:0]           p2_value_reg;
    logic [hlew_pkg::DAY_U_W-1:0]          p2_u_reg;
    logic [hlew_pkg::DAY_SHIFT-1:0]        p2_tlo_reg;
    logic [hlew_pkg::DAY_Q_W-1:0]          p2_q1_reg;
    logic [hlew_pkg::DAY_U_W-1:0]          p2_rem_full;
    logic [hlew_pkg::SEC_W-1:0]            p2_sec;

    assign p2_rem_full = p2_u_reg - hlew_pkg::DAY_U_W'(p2_q1_reg)
                                  * hlew_pkg::DAY_U_W'(hlew_pkg::DAY_ODD);
    assign p2_sec      = {p2_rem_full[hlew_pkg::SEC_W-hlew_pkg::DAY_SHIFT-1:0], p2_tlo_reg};

    // ------------------------------------------------------------------
    // Stage 3: shift by half an hour in interpolating mode, divide by 3600
    // ------------------------------------------------------------------
    logic                                  p3_weigh_reg;
    logic [hlew_pkg::NODE_W-1:0]           p3_node_reg;
    logic [hlew_pkg::HOUR_W-1:0]           p3_hour_reg;
    logic [hlew_pkg::DATA_W-1:0]           p3_value_reg;
    logic [hlew_pkg::SEC_W-1:0]            p3_sec_reg;
    logic [hlew_pkg::SEC_W-1:0]            p3_x;
    logic [hlew_pkg::HOUR_X_W+hlew_pkg::HOUR_RECIP_W-1:0] p3_prod;
    logic [hlew_pkg::HOUR_W-1:0]           p3_q2;

    always_comb
    begin
        if (!mode_reg)
            p3_x = p3_sec_reg;
        else if (p3_sec_reg >= hlew_pkg::SEC_W'(hlew_pkg::HALF_HOUR))
            p3_x = p3_sec_reg - hlew_pkg::SEC_W'(hlew_pkg::HALF_HOUR);
        else
            // before 00:30 the lower sample is hour 23 of the previous day
            p3_x = p3_sec_reg
                 + hlew_pkg::SEC_W'(hlew_pkg::SEC_PER_DAY - hlew_pkg::HALF_HOUR);
    end

    assign p3_prod = (hlew_pkg::HOUR_X_W+hlew_pkg::HOUR_RECIP_W)'(
                         p3_x[hlew_pkg::SEC_W-1:hlew_pkg::HOUR_SHIFT])
                   * (hlew_pkg::HOUR_X_W+hlew_pkg::HOUR_RECIP_W)'(hlew_pkg::HOUR_RECIP);
    assign p3_q2   = p3_prod[hlew_pkg::HOUR_RECIP_SHIFT+hlew_pkg::HOUR_W-1:
                             hlew_pkg::HOUR_RECIP_SHIFT];

    // ------------------------------------------------------------------
    // Stage 4: fraction, hour pair, table addresses; table access at exit
    // ------------------------------------------------------------------
    logic                                  p4_weigh_reg;
    logic [hlew_pkg::NODE_W-1:0]           p4_node_reg;
    logic [hlew_pkg::HOUR_W-1:0]           p4_hour_reg;
    logic [hlew_pkg::DATA_W-1:0]           p4_value_reg;
    logic [hlew_pkg::SEC_W-1:0]            p4_x_reg;
    logic [hlew_pkg::HOUR_W-1:0]           p4_lo_reg;
    logic [hlew_pkg::SEC_W-1:0]            p4_r_full;
    logic [hlew_pkg::FRAC_W-1:0]           p4_r;
    logic [hlew_pkg::HOUR_W-1:0]           p4_hi;
    logic [hlew_pkg::ADDR_W-1:0]           p4_row_base;
    logic [hlew_pkg::ADDR_W-1:0]           p4_addr_lo;
    logic [hlew_pkg::ADDR_W-1:0]           p4_addr_hi;
    logic [hlew_pkg::ADDR_W-1:0]           p4_addr_wr;
    logic                                  p4_hour_ok;
    logic                                  load_we;

    assign p4_r_full   = p4_x_reg - hlew_pkg::SEC_W'(p4_lo_reg)
                                  * hlew_pkg::SEC_W'(hlew_pkg::SEC_PER_HOUR);
    // clock-hour mode reads one sample: zero fraction selects the lower hour
    assign p4_r        = mode_reg ? p4_r_full[hlew_pkg::FRAC_W-1:0] : '0;
    assign p4_hi       = (p4_lo_reg == hlew_pkg::HOUR_W'(hlew_pkg::HOURS - 1))
                       ? '0 : p4_lo_reg + 1'b1;
    assign p4_row_base = hlew_pkg::ADDR_W'(p4_node_reg) * hlew_pkg::ADDR_W'(hlew_pkg::HOURS);
    assign p4_addr_lo  = p4_row_base + hlew_pkg::ADDR_W'(p4_lo_reg);
    assign p4_addr_hi  = p4_row_base + hlew_pkg::ADDR_W'(p4_hi);
    assign p4_addr_wr  = p4_row_base + hlew_pkg::ADDR_W'(p4_hour_reg);
    assign p4_hour_ok  = p4_hour_reg < hlew_pkg::HOUR_W'(hlew_pkg::HOURS);
    assign load_we     = vld_reg[4] && (p4_weigh_reg == hlew_pkg::REQ_WRITE) && p4_hour_ok;

    // Load table: one write port, two read ports, registered reads.
    // Writes and weigh reads share this stage, so program order holds.
    logic [hlew_pkg::DATA_W-1:0] load_mem [hlew_pkg::TABLE_DEPTH];
    logic [hlew_pkg::DATA_W-1:0] rd_lo_reg;
    logic [hlew_pkg::DATA_W-1:0] rd_hi_reg;

    always_ff @(posedge clk)
    begin
        if (load_we)
            load_mem[p4_addr_wr] <= p4_value_reg;
        rd_lo_reg <= load_mem[p4_addr_lo];
        rd_hi_reg <= load_mem[p4_addr_hi];
    end

    // ------------------------------------------------------------------
    // Stage 5: nonzero-mask read-modify-write, sample select, blend products
    // ------------------------------------------------------------------
    // A clear mask bit means the entry reads as zero, so stale table words
    // left from before reset never show. Row-valid flags stand in for the
    // cleared mask rows after reset.
    hlew_pkg::hour_mask_t          mask_mem [hlew_pkg::NODE_COUNT];
    hlew_pkg::hour_mask_t          mask_rd_reg;
    logic [hlew_pkg::NODE_COUNT-1:0] row_valid_reg;
    logic                          fwd_valid_reg;
    logic [hlew_pkg::NODE_W-1:0]   fwd_node_reg;
    hlew_pkg::hour_mask_t          fwd_mask_reg;

    logic [hlew_pkg::NODE_W-1:0]   p5_node_reg;
    logic [hlew_pkg::HOUR_W-1:0]   p5_hour_reg;
    logic                          p5_hour_ok_reg;
    logic                          p5_value_nz_reg;
    logic [hlew_pkg::HOUR_W-1:0]   p5_lo_reg;
    logic [hlew_pkg::HOUR_W-1:0]   p5_hi_reg;
    logic [hlew_pkg::FRAC_W-1:0]   p5_r_reg;
    logic                          fwd_hit;
    hlew_pkg::hour_mask_t          cur_mask;
    hlew_pkg::hour_mask_t          new_mask;
    logic                          mask_we;
    logic [hlew_pkg::DATA_W-1:0]   p5_a;
    logic [hlew_pkg::DATA_W-1:0]   p5_b;
    logic [hlew_pkg::NUM_W-1:0]    p5_pa;
    logic [hlew_pkg::NUM_W-1:0]    p5_pb;
    logic                          p5_unmatched;

    // the only write this read missed is the one at the same clock edge
    assign fwd_hit = fwd_valid_reg && (fwd_node_reg == p5_node_reg);

    always_comb
    begin
        if (fwd_hit)
            cur_mask = fwd_mask_reg;
        else if (row_valid_reg[p5_node_reg])
            cur_mask = mask_rd_reg;
        else
            cur_mask = '0;
        new_mask = cur_mask;
        new_mask[p5_hour_reg] = p5_value_nz_reg;
    end

    assign mask_we = vld_reg[5] && (p5_weigh_reg == hlew_pkg::REQ_WRITE) && p5_hour_ok_reg;

    assign p5_a         = cur_mask[p5_lo_reg] ? rd_lo_reg : '0;
    assign p5_b         = cur_mask[p5_hi_reg] ? rd_hi_reg : '0;
    assign p5_unmatched = (cur_mask == '0);
    assign p5_pa = hlew_pkg::NUM_W'(p5_a)
                 * hlew_pkg::NUM_W'(hlew_pkg::FRAC_W'(hlew_pkg::SEC_PER_HOUR) - p5_r_reg);
    assign p5_pb = hlew_pkg::NUM_W'(p5_b) * hlew_pkg::NUM_W'(p5_r_reg);

    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem[p5_node_reg] <= new_mask;
        mask_rd_reg <= mask_mem[p4_node_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mask_we)
                row_valid_reg[p5_node_reg] <= 1'b1;
            fwd_valid_reg <= mask_we;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_node_reg <= p5_node_reg;
        fwd_mask_reg <= new_mask;
    end

    // ------------------------------------------------------------------
    // Stages 6..8: rounded blend divided by 3600 via reciprocal
    // ------------------------------------------------------------------
    logic [hlew_pkg::NUM_W-1:0]      p6_pa_reg;
    logic [hlew_pkg::NUM_W-1:0]      p6_pb_reg;
    logic                            p6_unm_reg;
    logic [hlew_pkg::NUM_W-1:0]      p6_num;

    assign p6_num = p6_pa_reg + p6_pb_reg + hlew_pkg::NUM_W'(hlew_pkg::HALF_HOUR);

    logic [hlew_pkg::LOAD_Y_W-1:0]   p7_y_reg;
    logic                            p7_unm_reg;
    logic [hlew_pkg::LOAD_PP_W-1:0]  p7_pl;
    logic [hlew_pkg::LOAD_PP_W-1:0]  p7_ph;

    // 40x40 reciprocal product split in two 40x20 partials
    assign p7_pl = hlew_pkg::LOAD_PP_W'(p7_y_reg)
                 * hlew_pkg::LOAD_PP_W'(hlew_pkg::LOAD_RECIP[hlew_pkg::LOAD_RECIP_HALF-1:0]);
    assign p7_ph = hlew_pkg::LOAD_PP_W'(p7_y_reg)
                 * hlew_pkg::LOAD_PP_W'(hlew_pkg::LOAD_RECIP[hlew_pkg::LOAD_RECIP_W-1:
                                                             hlew_pkg::LOAD_RECIP_HALF]);

    logic [hlew_pkg::LOAD_PP_W-1:0]  p8_pl_reg;
    logic [hlew_pkg::LOAD_PP_W-1:0]  p8_ph_reg;
    logic                            p8_unm_reg;
    logic [hlew_pkg::LOAD_SUM_W-1:0] p8_sum;
    logic [hlew_pkg::DATA_W-1:0]     p8_load;

    assign p8_sum  = hlew_pkg::LOAD_SUM_W'(p8_pl_reg)
                   + (hlew_pkg::LOAD_SUM_W'(p8_ph_reg) << hlew_pkg::LOAD_RECIP_HALF);
    // quotient never exceeds the larger sample, so 32 bits hold it
    assign p8_load = p8_sum[hlew_pkg::LOAD_RECIP_SHIFT+hlew_pkg::DATA_W-1:
                            hlew_pkg::LOAD_RECIP_SHIFT];

    // ------------------------------------------------------------------
    // Stages 9..10: scale, round half up, saturate
    // ------------------------------------------------------------------
    logic [hlew_pkg::DATA_W-1:0]     p9_load_reg;
    logic                            p9_unm_reg;
    logic [hlew_pkg::PROD_W-1:0]     p9_prod;

    assign p9_prod = hlew_pkg::PROD_W'(p9_load_reg) * hlew_pkg::PROD_W'(scale_reg);

    logic [hlew_pkg::PROD_W-1:0]     p10_prod_reg;
    logic                            p10_unm_reg;
    logic [hlew_pkg::PROD_W-1:0]     p10_round;
    logic [hlew_pkg::PROD_W-hlew_pkg::WEIGHT_FRAC-1:0] p10_w;
    hlew_pkg::rsp_entry_t            p10_entry;

    assign p10_round = p10_prod_reg + hlew_pkg::ROUND_HALF;
    assign p10_w     = p10_round[hlew_pkg::PROD_W-1:hlew_pkg::WEIGHT_FRAC];
    assign p10_entry.weight    = (|p10_w[hlew_pkg::PROD_W-hlew_pkg::WEIGHT_FRAC-1:
                                         hlew_pkg::DATA_W])
                               ? '1 : p10_w[hlew_pkg::DATA_W-1:0];
    assign p10_entry.unmatched = p10_unm_reg;

    // ------------------------------------------------------------------
    // Pipeline payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        p1_weigh_reg    <= req.req_type;
        p1_node_reg     <= req.node_index;
        p1_hour_reg     <= req.hour_slot;
        p1_value_reg    <= req.load_value;
        p1_time_reg     <= req.departure_time;

        p2_weigh_reg    <= p1_weigh_reg;
        p2_node_reg     <= p1_node_reg;
        p2_hour_reg     <= p1_hour_reg;
        p2_value_reg    <= p1_value_reg;
        p2_u_reg        <= p1_u;
        p2_tlo_reg      <= p1_time_reg[hlew_pkg::DAY_SHIFT-1:0];
        p2_q1_reg       <= p1_prod[hlew_pkg::DAY_RECIP_SHIFT+hlew_pkg::DAY_Q_W-1:
                                   hlew_pkg::DAY_RECIP_SHIFT];

        p3_weigh_reg    <= p2_weigh_reg;
        p3_node_reg     <= p2_node_reg;
        p3_hour_reg     <= p2_hour_reg;
        p3_value_reg    <= p2_value_reg;
        p3_sec_reg      <= p2_sec;

        p4_weigh_reg    <= p3_weigh_reg;
        p4_node_reg     <= p3_node_reg;
        p4_hour_reg     <= p3_hour_reg;
        p4_value_reg    <= p3_value_reg;
        p4_x_reg        <= p3_x;
        p4_lo_reg       <= p3_q2;

        p5_weigh_reg    <= p4_weigh_reg;
        p5_node_reg     <= p4_node_reg;
        p5_hour_reg     <= p4_hour_reg;
        p5_hour_ok_reg  <= p4_hour_ok;
        p5_value_nz_reg <= (p4_value_reg != '0);
        p5_lo_reg       <= p4_lo_reg;
        p5_hi_reg       <= p4_hi;
        p5_r_reg        <= p4_r;

        p6_pa_reg       <= p5_pa;
        p6_pb_reg       <= p5_pb;
        p6_unm_reg      <= p5_unmatched;

        p7_y_reg        <= p6_num[hlew_pkg::NUM_W-1:hlew_pkg::HOUR_SHIFT];
        p7_unm_reg      <= p6_unm_reg;

        p8_pl_reg       <= p7_pl;
        p8_ph_reg       <= p7_ph;
        p8_unm_reg      <= p7_unm_reg;

        p9_load_reg     <= p8_load;
        p9_unm_reg      <= p8_unm_reg;

        p10_prod_reg    <= p9_prod;
        p10_unm_reg     <= p9_unm_reg;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    hlew_pkg::rsp_entry_t           fifo_mem [hlew_pkg::FIFO_DEPTH];
    logic [hlew_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [hlew_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [hlew_pkg::CNT_W-1:0]     fifo_count_reg;
    logic                           fifo_push;

    assign fifo_push = vld_reg[10];

    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem[wr_ptr_reg] <= p10_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (fifo_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rsp_xfer)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({fifo_push, rsp_xfer})
                2'b10:   fifo_count_reg <= fifo_count_reg + 1'b1;
                2'b01:   fifo_count_reg <= fifo_count_reg - 1'b1;
                default: fifo_count_reg <= fifo_count_reg;
            endcase
        end
    end

    assign rsp.valid          = (fifo_count_reg != '0);
    assign rsp.crowd_weight   = fifo_mem[rd_ptr_reg].weight;
    assign rsp.stop_unmatched = fifo_mem[rd_ptr_reg].unmatched;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= hlew_pkg::CNT_W'(hlew_pkg::FIFO_DEPTH))
        else $error("credit counter above queue depth");

    a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= pending_reg)
        else $error("queued results exceed outstanding credits");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count_reg < hlew_pkg::CNT_W'(hlew_pkg::FIFO_DEPTH)))
        else $error("result pushed into full queue");

    a_fwd_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> row_valid_reg[fwd_node_reg])
        else $error("forwarded mask row not marked valid");

    a_mask_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        mask_we |=> (fwd_valid_reg && (fwd_node_reg == $past(p5_node_reg))))
        else $error("mask write not captured for forwarding");

endmodule

`default_nettype wire

>>> tb/tb_hourly_load_edge_weight_unit.sv
// Self-checking bench for hourly_load_edge_weight_unit: load-table writes and edge weighs,
// checked against a cycle-free predictor; scale and mode set over APB between phases.
// Depends on hlew_pkg, hlew_req_if, hlew_rsp_if and the unit itself.
`timescale 1ns / 100ps

module tb_hourly_load_edge_weight_unit;
    import hlew_pkg::*;

    // No transfer on either channel for this many cycles means the unit hung.
    // The slowest correct stretch (drain + APB + stall) is well under this limit.
    localparam int WATCHDOG_LIMIT = 1000;
    // Counted (non-ignored) items per random phase.
    localparam int PHASE_ITEMS    = 60;
    localparam int N_PHASES       = 7;

    typedef struct {
        logic              req_type;
        logic [NODE_W-1:0] node;
        logic [HOUR_W-1:0] hour;
        logic [DATA_W-1:0] load;
        logic [TIME_W-1:0] dtime;
    } load_req_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    hlew_req_if req_ch ();
    hlew_rsp_if rsp_ch ();

    hourly_load_edge_weight_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Shadow state of the unit: load table, row has-data flags, registers
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0] hourly_load [NODE_COUNT][HOURS];
    bit                row_loaded  [NODE_COUNT];
    logic [DATA_W-1:0] scale_cfg;
    logic              interp_mode;

    load_req_t   pending_reqs[$];      // items waiting for the driver
    rsp_entry_t  expected_weights[$];  // weights predicted, not yet returned
    int unsigned reqs_issued;          // items put on the req channel (driver)
    int unsigned reqs_taken;           // req transfers seen (monitor)
    int unsigned quiet_cycles;
    int          fail_cnt;

    // Weight of one edge from the shadow state. Interpolating mode treats each
    // hourly value as a sample at hh:30 and blends the two neighbors, wrapping
    // hour 23 -> hour 0; before 00:30 the pair is (23, 0) with r = sec + 1800.
    function automatic rsp_entry_t predict_weight(input logic [NODE_W-1:0] node,
                                                  input logic [TIME_W-1:0] dtime);
        logic [31:0]       sec;
        logic [31:0]       r;
        logic [4:0]        lo;
        logic [4:0]        hi;
        logic [63:0]       num;
        logic [63:0]       prod;
        logic [DATA_W-1:0] load;
        rsp_entry_t        res;
        sec = dtime % SEC_PER_DAY;
        if (!interp_mode)
        begin
            load = hourly_load[node][sec / SEC_PER_HOUR];
        end
        else
        begin
            if (sec >= HALF_HOUR)
            begin
                lo = 5'((sec - HALF_HOUR) / SEC_PER_HOUR);
                r  = (sec - HALF_HOUR) % SEC_PER_HOUR;
            end
            else
            begin
                lo = 5'(HOURS - 1);
                r  = sec + HALF_HOUR;
            end
            hi   = (lo == HOURS - 1) ? 5'd0 : lo + 5'd1;
            num  = 64'(hourly_load[node][lo]) * 64'(SEC_PER_HOUR - r)
                 + 64'(hourly_load[node][hi]) * 64'(r) + 64'(HALF_HOUR);
            load = 32'(num / 64'(SEC_PER_HOUR));
        end
        // Q24.8 * Q16.16 -> Q40.24, round half up, saturate to 32 bits
        prod = 64'(load) * 64'(scale_cfg) + 64'h80_0000;
        res.weight    = (prod[63:56] != 8'd0) ? 32'hFFFF_FFFF : prod[55:24];
        res.unmatched = !row_loaded[node];
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: req transfers feed the predictor, rsp transfers are checked.
    // Everything is sampled at the rising edge; inputs moved at the falling one.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_entry_t exp_rsp;
        bit         any_load;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                reqs_taken++;
                if (req_ch.req_type == REQ_WEIGH)
                begin
                    expected_weights.push_back(predict_weight(req_ch.node_index,
                                                              req_ch.departure_time));
                end
                else if (req_ch.hour_slot < HOURS)
                begin
                    // slots 24..31 are dropped by the unit
                    hourly_load[req_ch.node_index][req_ch.hour_slot] = req_ch.load_value;
                    any_load = 1'b0;
                    for (int h = 0; h < HOURS; h++)
                        if (hourly_load[req_ch.node_index][h] != '0)
                            any_load = 1'b1;
                    row_loaded[req_ch.node_index] = any_load;
                end
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("result transfer with no weigh outstanding: weight %0h unmatched %0b",
                           rsp_ch.crowd_weight, rsp_ch.stop_unmatched);
                    fail_cnt++;
                end
                else
                begin
                    exp_rsp = expected_weights.pop_front();
                    if (rsp_ch.crowd_weight !== exp_rsp.weight)
                    begin
                        $error("crowd_weight: expected %0h, got %0h",
                               exp_rsp.weight, rsp_ch.crowd_weight);
                        fail_cnt++;
                    end
                    if (rsp_ch.stop_unmatched !== exp_rsp.unmatched)
                    begin
                        $error("stop_unmatched: expected %0b, got %0b",
                               exp_rsp.unmatched, rsp_ch.stop_unmatched);
                        fail_cnt++;
                    end
                end
            end

            // watchdog on transfer activity
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A new item
    // goes out only once the one on the channel has been taken.
    // ---------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(negedge clk)
    begin
        load_req_t nxt_req;
        if (rst_n && reqs_issued == reqs_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt_req = pending_reqs.pop_front();
                req_ch.req_type       <= nxt_req.req_type;
                req_ch.node_index     <= nxt_req.node;
                req_ch.hour_slot      <= nxt_req.hour;
                req_ch.load_value     <= nxt_req.load;
                req_ch.departure_time <= nxt_req.dtime;
                req_ch.valid          <= 1'b1;
                reqs_issued++;
                if (burst_left <= 1)
                begin
                    // one burst in four runs straight into the next
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: rotates through no stalls, random 25% stalls, and long stall
    // bursts that back up the result queue into req.ready.
    // ---------------------------------------------------------------------
    int unsigned rdy_cycle;
    int unsigned stall_left;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rdy_cycle++;
            case ((rdy_cycle / 300) % 3)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left--;
                        rsp_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        rsp_ch.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            stall_left = $urandom_range(1, 16);
                    end
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_write(input logic [NODE_W-1:0] node, input logic [HOUR_W-1:0] hour,
                               input logic [DATA_W-1:0] load);
        load_req_t r;
        r.req_type = REQ_WRITE;
        r.node     = node;
        r.hour     = hour;
        r.load     = load;
        r.dtime    = $urandom;   // don't care on writes
        pending_reqs.push_back(r);
    endtask

    task automatic queue_weigh(input logic [NODE_W-1:0] node, input logic [TIME_W-1:0] dtime);
        load_req_t r;
        r.req_type = REQ_WEIGH;
        r.node     = node;
        r.hour     = HOUR_W'($urandom);   // don't care on weighs
        r.load     = $urandom;
        r.dtime    = dtime;
        pending_reqs.push_back(r);
    endtask

    // Mostly a small set of hot rows (0..7, 248..255) so weighs hit written data
    function automatic logic [NODE_W-1:0] pick_node();
        int unsigned hot;
        hot = $urandom_range(0, 15);
        if ($urandom_range(0, 4) == 0)
            return NODE_W'($urandom);
        return (hot < 8) ? NODE_W'(hot) : NODE_W'(240 + hot);
    endfunction

    function automatic logic [DATA_W-1:0] rand_load();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 4096);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic load_req_t random_req();
        load_req_t r;
        r.node = pick_node();
        r.load = rand_load();
        r.hour = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom_range(24, 31))
                                             : HOUR_W'($urandom_range(0, HOURS - 1));
        r.req_type = ($urandom_range(0, 99) < 35) ? REQ_WRITE : REQ_WEIGH;
        case ($urandom_range(0, 3))
            0: r.dtime = $urandom;
            1: r.dtime = $urandom_range(0, SEC_PER_DAY - 1);
            // close to an hour center
            2: r.dtime = $urandom_range(0, HOURS - 1) * SEC_PER_HOUR
                       + $urandom_range(HALF_HOUR - 3, HALF_HOUR + 3);
            // on an hour boundary or one second before the next, some days later
            default: r.dtime = SEC_PER_DAY * $urandom_range(0, 49000)
                             + $urandom_range(0, HOURS - 1) * SEC_PER_HOUR
                             + (($urandom_range(0, 1) != 0) ? 0 : SEC_PER_HOUR - 1);
        endcase
        return r;
    endfunction

    // Wait (at falling edges, where the counters and queues are stable) until
    // every queued item went out and every predicted weight came back.
    task automatic drain_pipe();
        while (pending_reqs.size() != 0 || reqs_issued != reqs_taken
               || expected_weights.size() != 0)
            @(negedge clk);
    endtask

    // APB write then readback of one register; call at a falling edge with the unit idle.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd_mask;
        rd_mask = (idx == REG_MODE) ? 32'h1 : 32'hFFFF_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk) penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_SCALE)
            scale_cfg = value;
        else
            interp_mode = value[0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk) penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & rd_mask) !== (value & rd_mask))
        begin
            $error("prdata: expected %0h, got %0h", value & rd_mask, prdata & rd_mask);
            fail_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0] phase_scale [N_PHASES];
    logic              phase_mode  [N_PHASES];

    initial
    begin
        load_req_t r;
        int        counted;

        // every input known from time zero
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_WRITE;
        req_ch.node_index     = '0;
        req_ch.hour_slot      = '0;
        req_ch.load_value     = '0;
        req_ch.departure_time = '0;
        rsp_ch.ready          = 1'b0;
        reqs_issued           = 0;
        reqs_taken            = 0;
        quiet_cycles          = 0;
        fail_cnt              = 0;
        burst_left            = 0;
        gap_left              = 0;
        rdy_cycle             = 0;
        stall_left            = 0;
        scale_cfg             = SCALE_RESET;
        interp_mode           = MODE_RESET;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            row_loaded[n] = 1'b0;
            for (int h = 0; h < HOURS; h++)
                hourly_load[n][h] = '0;
        end

        // extremes first, then mixed settings
        phase_scale = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, $urandom_range(1, 32'h3_0000),
                        $urandom, 32'h1, 32'h1_0000};
        phase_mode  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset settings (scale 1.0, interpolating)
        queue_weigh(8'd0, 32'd0);                     // never-written row: 0, unmatched
        queue_write(8'd0, 5'd0, 32'h100);
        queue_write(8'd0, 5'd23, 32'h300);
        queue_write(8'd0, 5'd1, 32'h200);
        queue_weigh(8'd0, 32'd1800);                  // exactly on hour 0 center
        queue_weigh(8'd0, 32'd0);                     // before first center: 23/0 blend
        queue_weigh(8'd0, 32'd1799);
        queue_weigh(8'd0, 32'd5399);
        queue_weigh(8'd0, 32'd86399);                 // last second of the day
        queue_weigh(8'd0, 32'd86400);                 // wraps to midnight
        queue_weigh(8'd0, 32'hFFFF_FFFF);
        queue_write(8'd0, 5'd24, 32'd5);              // out-of-range slots: dropped
        queue_write(8'd0, 5'd31, 32'd7);
        queue_weigh(8'd0, 32'd88200);
        queue_write(8'd255, 5'd23, 32'hFFFF_FFFF);
        queue_write(8'd255, 5'd0, 32'hFFFF_FFFF);
        queue_weigh(8'd255, 32'd0);                   // largest load
        queue_weigh(8'd255, 32'd43200);               // zero hours on a flagged row
        queue_weigh(8'd255, 32'd84600);
        queue_write(8'd9, 5'd5, 32'd1);
        queue_weigh(8'd9, 32'd19800);                 // rounds to zero, still matched
        queue_write(8'd9, 5'd5, 32'd0);               // row back to all zero
        queue_weigh(8'd9, 32'd19800);
        queue_weigh(8'd9, 32'd21000);
        drain_pipe();

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++)
        begin
            // writes leave no result, so let the pipe empty past its latency
            repeat (20) @(negedge clk);
            cfg_write(REG_SCALE, phase_scale[p]);
            cfg_write(REG_MODE, {31'd0, phase_mode[p]});
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // fill one whole row, then the weighs that follow see real data
                    r.node = pick_node();
                    for (int h = 0; h < HOURS; h++)
                        queue_write(r.node, HOUR_W'(h), rand_load());
                    counted += HOURS;
                end
                else
                begin
                    r = random_req();
                    pending_reqs.push_back(r);
                    if (r.req_type == REQ_WEIGH || r.hour < HOURS)
                        counted++;
                end
            end
            // sender sits still here until every weight is back
            drain_pipe();
        end

        repeat (30) @(negedge clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
